### design/tat_pkg.sv
// Shared types and constants for the TTL address table.
// Used by every module of the block; depends on nothing.
`default_nettype none
package tat_pkg;

   localparam int unsigned MODE_W   = 3;
   localparam int unsigned FKEY_W   = 64;
   localparam int unsigned TIME_W   = 31;
   localparam int unsigned REQ_W    = 136;
   localparam int unsigned RSP_W    = 40;

   localparam logic [TIME_W-1:0] NEVER_EXPIRE = 31'h7fff_ffff;

   localparam logic [MODE_W-1:0] MODE_ADD     = 3'd0;
   localparam logic [MODE_W-1:0] MODE_REFRESH = 3'd1;
   localparam logic [MODE_W-1:0] MODE_REMOVE  = 3'd2;
   localparam logic [MODE_W-1:0] MODE_LOOKUP  = 3'd3;
   localparam logic [MODE_W-1:0] MODE_PURGE   = 3'd4;

   typedef enum logic [2:0] {
      OP_ADD,
      OP_REFRESH,
      OP_REMOVE,
      OP_LOOKUP,
      OP_PURGE,
      OP_NONE
   } tat_op_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_DONE
   } tat_state_type;

   typedef struct packed {
      tat_op_type        op;
      logic [FKEY_W-1:0] key;
      logic [TIME_W-1:0] now;
      logic [TIME_W-1:0] expiry;
   } tat_cmd_type;

endpackage
`default_nettype wire

### design/tat_front.sv
// Front end: unpacks a request beat, decodes the mode and works out the expiry.
// Depends on tat_pkg; feeds tat_cmd_queue.
`default_nettype none
module tat_front (
   input  wire logic                        req_tvalid,
   output logic                             req_tready,
   input  wire logic [tat_pkg::REQ_W-1:0]   req_tdata,
   input  wire logic                        q_full,
   output logic                             q_push,
   output tat_pkg::tat_cmd_type             q_cmd
);
   import tat_pkg::*;

   logic [MODE_W-1:0] mode;
   logic [TIME_W-1:0] ttl;
   logic [TIME_W:0]   sum;

   assign mode = req_tdata[2:0];
   assign ttl  = req_tdata[128:98];
   assign sum  = {1'b0, req_tdata[97:67]} + {1'b0, ttl};

   assign req_tready = !q_full;
   assign q_push     = req_tvalid && !q_full;

   always_comb begin
      q_cmd.key = req_tdata[66:3];
      q_cmd.now = req_tdata[97:67];
      // zero ttl or overflow past the top of the range both mean never expire
      if (ttl == '0 || sum[TIME_W]) begin
         q_cmd.expiry = NEVER_EXPIRE;
      end else begin
         q_cmd.expiry = sum[TIME_W-1:0];
      end
      case (mode)
         MODE_ADD:     q_cmd.op = OP_ADD;
         MODE_REFRESH: q_cmd.op = OP_REFRESH;
         MODE_REMOVE:  q_cmd.op = OP_REMOVE;
         MODE_LOOKUP:  q_cmd.op = OP_LOOKUP;
         MODE_PURGE:   q_cmd.op = OP_PURGE;
         default:      q_cmd.op = OP_NONE;
      endcase
   end

endmodule
`default_nettype wire

### design/tat_cmd_queue.sv
// Two-entry command queue between the front end and the table sequencer.
// Depends on tat_pkg.
`default_nettype none
module tat_cmd_queue (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push,
   input  wire tat_pkg::tat_cmd_type push_cmd,
   output logic                      full,
   output logic                      valid,
   input  wire logic                 pop,
   output tat_pkg::tat_cmd_type      pop_cmd
);
   import tat_pkg::*;

   tat_cmd_type entry_ff [2];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  count_ff,  count_in;
   logic        do_pop;

   assign full    = (count_ff == 2'd2);
   assign valid   = (count_ff != 2'd0);
   assign do_pop  = pop && valid;
   assign pop_cmd = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule
`default_nettype wire

### design/tat_back.sv
// Table sequencer: slot memories, one-slot-per-cycle scan and the result register.
// Depends on tat_pkg; takes commands from tat_cmd_queue.
`default_nettype none
module tat_back #(
   parameter int unsigned CAPACITY = 64,
   parameter int unsigned KEY_BITS = 64
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      q_valid,
   input  wire tat_pkg::tat_cmd_type      q_cmd,
   output logic                           q_pop,
   output logic                           rsp_tvalid,
   input  wire logic                      rsp_tready,
   output logic [tat_pkg::RSP_W-1:0]      rsp_tdata
);
   import tat_pkg::*;

   localparam int unsigned IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

   // slot storage
   logic                val_mem [CAPACITY];
   logic [KEY_BITS-1:0] key_mem [CAPACITY];
   logic [TIME_W-1:0]   exp_mem [CAPACITY];
   logic                val_rd_ff;
   logic [KEY_BITS-1:0] key_rd_ff;
   logic [TIME_W-1:0]   exp_rd_ff;

   tat_state_type       state_ff, state_in;
   tat_cmd_type         cmd_ff, cmd_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic                ev_vld_ff, ev_vld_in;
   logic [IDX_W-1:0]    ev_idx_ff, ev_idx_in;
   logic                pass_ff, pass_in;
   logic                hit_ff, hit_in;
   logic                placed_ff, placed_in;
   logic [TIME_W-1:0]   exp_out_ff, exp_out_in;
   logic                rsp_vld_ff, rsp_vld_in;
   logic [RSP_W-1:0]    rsp_data_ff, rsp_data_in;

   logic                issue;
   logic                last_eval;
   logic [IDX_W-1:0]    rd_addr;
   logic [IDX_W-1:0]    wr_addr;
   logic                val_we, key_we, exp_we;
   logic                val_wd;
   logic [TIME_W-1:0]   exp_wd;
   logic [KEY_BITS-1:0] cmd_key;
   logic                match, live, free_here;
   logic                out_free;

   assign cmd_key   = cmd_ff.key[KEY_BITS-1:0];
   assign issue     = (cnt_ff < CNT_W'(CAPACITY));
   assign last_eval = ev_vld_ff && (ev_idx_ff == IDX_W'(CAPACITY - 1));
   assign rd_addr   = issue ? cnt_ff[IDX_W-1:0] : '0;
   assign match     = val_rd_ff && (key_rd_ff == cmd_key);
   assign live      = match && (exp_rd_ff > cmd_ff.now);
   assign free_here = !val_rd_ff || (hit_ff && match);
   assign out_free  = !rsp_vld_ff || rsp_tready;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (cnt_ff == CNT_W'(CAPACITY - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (q_valid) begin
               state_in = (q_cmd.op == OP_NONE) ? ST_DONE : ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (last_eval && !(cmd_ff.op == OP_ADD && !pass_ff)) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      q_pop       = 1'b0;
      cmd_in      = cmd_ff;
      cnt_in      = cnt_ff;
      ev_vld_in   = 1'b0;
      ev_idx_in   = ev_idx_ff;
      pass_in     = pass_ff;
      hit_in      = hit_ff;
      placed_in   = placed_ff;
      exp_out_in  = exp_out_ff;
      rsp_vld_in  = rsp_vld_ff && !rsp_tready;
      rsp_data_in = rsp_data_ff;
      wr_addr     = ev_idx_ff;
      val_we      = 1'b0;
      key_we      = 1'b0;
      exp_we      = 1'b0;
      val_wd      = 1'b0;
      exp_wd      = cmd_ff.expiry;

      case (state_ff)
         ST_CLEAR: begin
            wr_addr = cnt_ff[IDX_W-1:0];
            val_we  = 1'b1;
            cnt_in  = (cnt_ff == CNT_W'(CAPACITY - 1)) ? '0 : cnt_ff + 1'b1;
         end
         ST_IDLE: begin
            if (q_valid) begin
               q_pop     = 1'b1;
               cmd_in    = q_cmd;
               cnt_in    = '0;
               pass_in   = 1'b0;
               hit_in    = 1'b0;
               placed_in = 1'b0;
               exp_out_in = '0;
            end
         end
         ST_SCAN: begin
            if (issue) begin
               cnt_in    = cnt_ff + 1'b1;
               ev_vld_in = 1'b1;
               ev_idx_in = cnt_ff[IDX_W-1:0];
            end
            if (ev_vld_ff) begin
               case (cmd_ff.op)
                  OP_ADD: begin
                     if (!pass_ff) begin
                        if (live) hit_in = 1'b1;
                     end else if (free_here && !placed_ff) begin
                        // lowest free slot: any later frees lie above it
                        val_we    = 1'b1;
                        key_we    = 1'b1;
                        exp_we    = 1'b1;
                        val_wd    = 1'b1;
                        placed_in = 1'b1;
                     end else if (hit_ff && match) begin
                        val_we = 1'b1;
                     end
                  end
                  OP_REFRESH: begin
                     if (live && !hit_ff) begin
                        exp_we = 1'b1;
                        hit_in = 1'b1;
                     end
                  end
                  OP_REMOVE: begin
                     if (match) val_we = 1'b1;
                  end
                  OP_LOOKUP: begin
                     if (live && !hit_ff) begin
                        hit_in     = 1'b1;
                        exp_out_in = exp_rd_ff;
                     end
                  end
                  OP_PURGE: begin
                     if (val_rd_ff && exp_rd_ff <= cmd_ff.now) val_we = 1'b1;
                  end
                  default: ;
               endcase
            end
            if (last_eval && cmd_ff.op == OP_ADD && !pass_ff) begin
               pass_in = 1'b1;
               cnt_in  = '0;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_vld_in  = 1'b1;
               rsp_data_in = '0;
               case (cmd_ff.op)
                  OP_ADD:     rsp_data_in[0] = !placed_ff;
                  OP_REFRESH: rsp_data_in[0] = !hit_ff;
                  OP_LOOKUP: begin
                     rsp_data_in[1]    = hit_ff;
                     rsp_data_in[32:2] = exp_out_ff;
                  end
                  default: ;
               endcase
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_CLEAR;
         cnt_ff     <= '0;
         ev_vld_ff  <= 1'b0;
         pass_ff    <= 1'b0;
         hit_ff     <= 1'b0;
         placed_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         cnt_ff     <= cnt_in;
         ev_vld_ff  <= ev_vld_in;
         pass_ff    <= pass_in;
         hit_ff     <= hit_in;
         placed_ff  <= placed_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      ev_idx_ff   <= ev_idx_in;
      exp_out_ff  <= exp_out_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (val_we) val_mem[wr_addr] <= val_wd;
      val_rd_ff <= val_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (key_we) key_mem[wr_addr] <= cmd_key;
      key_rd_ff <= key_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (exp_we) exp_mem[wr_addr] <= exp_wd;
      exp_rd_ff <= exp_mem[rd_addr];
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_eval_in_scan: assert property (@(posedge clock) disable iff (reset)
      ev_vld_ff |-> state_ff == ST_SCAN)
      else $error("slot evaluated outside a scan");

   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> (state_ff == ST_IDLE && q_valid))
      else $error("command popped while busy");

   a_placed_add: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN && placed_ff) |-> (cmd_ff.op == OP_ADD && pass_ff))
      else $error("slot placed outside add second pass");

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_vld_ff && !rsp_data_ff[1]) |-> rsp_data_ff[32:2] == '0)
      else $error("expiry reported without a hit");

   a_no_write_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE || state_ff == ST_DONE) |-> !(val_we || key_we || exp_we))
      else $error("table written while not scanning");

endmodule
`default_nettype wire

### design/ttl_address_table_unit.sv
// TTL address table unit, top level.
// Request beats carry one operation: add, refresh, remove, lookup or purge.
// Each beat returns exactly one response beat, in request order.
// req: tdata = mode[2:0], key[66:3], now[97:67], ttl[128:98], zero fill to 136.
// rsp: tdata = status[0], found[1], expire_time[32:2], zero fill to 40.
// The front end decodes a beat and works out its expiry in the same cycle and
// drops it into a two-entry queue, so up to two requests are taken while the
// sequencer is busy. The sequencer walks the slot memories one slot per clock
// with a registered read; an add walks the table twice (find a live copy, then
// free copies and place). Unused mode codes answer zero. After reset the valid
// bits are swept clear, one slot per cycle; requests queue up but are not
// processed until the sweep ends.
// The response sits in an output register; a stalled receiver holds it there
// while the next item is already scanned, and only the final hand-off waits.
// Depends on tat_pkg, tat_front, tat_cmd_queue, tat_back.
`default_nettype none
module ttl_address_table_unit #(
   parameter int unsigned CAPACITY = 64,
   parameter int unsigned KEY_BITS = 64
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_tvalid,
   output logic                           req_tready,
   // mode, key, now, ttl from bit 0 up; zero fill
   input  wire logic [tat_pkg::REQ_W-1:0] req_tdata,
   output logic                           rsp_tvalid,
   input  wire logic                      rsp_tready,
   // status, found, expire_time from bit 0 up; zero fill
   output logic [tat_pkg::RSP_W-1:0]      rsp_tdata
);
   import tat_pkg::*;

   logic        q_full;
   logic        q_push;
   logic        q_valid;
   logic        q_pop;
   tat_cmd_type push_cmd;
   tat_cmd_type pop_cmd;

   tat_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_cmd      (push_cmd)
   );

   tat_cmd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (push_cmd),
      .full     (q_full),
      .valid    (q_valid),
      .pop      (q_pop),
      .pop_cmd  (pop_cmd)
   );

   tat_back #(
      .CAPACITY (CAPACITY),
      .KEY_BITS (KEY_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_cmd      (pop_cmd),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
`default_nettype wire
